### src/dhtm_pkg.sv
// Shared constants and types for the DH transform pipeline.
package dhtm_pkg;

  // Widths of the CORDIC datapath
  localparam int ZW = 34;                 // residual angle, Q30 with headroom
  localparam int XW = 32;                 // x/y vector components, Q30

  // Q30 constants
  localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [XW-1:0] GainQ30   = 32'sd652032874;

  // Saturation limits
  localparam logic signed [15:0] TrigMax = 16'sd16384;
  localparam logic signed [15:0] TrigMin = -16'sd16384;
  localparam logic signed [15:0] LenMax  = 16'sd32767;
  localparam logic signed [15:0] LenMin  = -16'sd32768;

  // Largest number of rotation steps the pipeline builds
  localparam int MaxIter = 24;

  // atan(2^-i) in Q30, truncated
  localparam logic [31:0] AtanQ30 [MaxIter] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef logic signed [15:0] word_t;

endpackage

### src/dh_transform_matrix.sv
// Top level: standard DH link transform, pipelined CORDIC plus product stages.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   input   | in        | valid_i / stall_o  | link_length, link_twist, link_offset,
//           |           |                    | joint_angle
//   result  | out       | valid_o / stall_i  | r00 r01 r02 p0 r10 r11 r12 p1 r21 r22 p2
//
// Stages, in order: one fold stage, one stage per CORDIC micro-rotation (iterations
// capped at 24), one rounding stage, one multiply stage, one output register. One item
// enters per cycle while stall_o is low; two CORDIC lanes run side by side.
// Reset clears only the stage valid bits. A stall freezes only the stages that are
// full back to the output, so bubbles close up and stall_o rises only when every
// stage holds an item and the output is stalled.
module dh_transform_matrix import dhtm_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  word_t link_length_i,
  input  word_t link_twist_i,
  input  word_t link_offset_i,
  input  word_t joint_angle_i,
  output logic  valid_o,
  input  logic  stall_i,
  output word_t r00_o,
  output word_t r01_o,
  output word_t r02_o,
  output word_t p0_o,
  output word_t r10_o,
  output word_t r11_o,
  output word_t r12_o,
  output word_t p1_o,
  output word_t r21_o,
  output word_t r22_o,
  output word_t p2_o
);

  localparam int NumIter = (CORDIC_ITERATIONS > MaxIter) ? MaxIter : CORDIC_ITERATIONS;
  localparam int NumStg  = NumIter + 4;

  logic [NumStg-1:0] valid_q, valid_d;
  logic [NumStg-1:0] ready;

  // A stage may load unless it and everything after it is full and the output stalls
  for (genvar k = 0; k < NumStg; k++) begin : g_ready
    assign ready[k] = !stall_i || !(&valid_q[NumStg-1:k]);
  end

  assign valid_d = (ready & {valid_q[NumStg-2:0], valid_i}) | (~ready & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stall_o = !ready[0];
  assign valid_o = valid_q[NumStg-1];

  // Delay lines for a (to the multiply stage) and d (to the output)
  word_t a_q [NumIter+2];
  word_t d_q [NumStg];

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      a_q[0] <= link_length_i;
      d_q[0] <= link_offset_i;
    end
  end

  for (genvar k = 1; k < NumStg; k++) begin : g_dline
    always_ff @(posedge clk_i) begin
      if (ready[k]) begin
        d_q[k] <= d_q[k-1];
      end
    end
    if (k < NumIter + 2) begin : g_aline
      always_ff @(posedge clk_i) begin
        if (ready[k]) begin
          a_q[k] <= a_q[k-1];
        end
      end
    end
  end

  // Sine and cosine of both angles
  word_t sin_t, cos_t, sin_a, cos_a;

  dhtm_cordic #(.NumIter(NumIter)) u_cordic_theta (
    .clk_i   (clk_i),
    .en_i    (ready[NumIter+1:0]),
    .angle_i (joint_angle_i),
    .sin_o   (sin_t),
    .cos_o   (cos_t)
  );

  dhtm_cordic #(.NumIter(NumIter)) u_cordic_alpha (
    .clk_i   (clk_i),
    .en_i    (ready[NumIter+1:0]),
    .angle_i (link_twist_i),
    .sin_o   (sin_a),
    .cos_o   (cos_a)
  );

  // Products and output register
  dhtm_mult u_mult (
    .clk_i   (clk_i),
    .en_i    (ready[NumIter+3:NumIter+2]),
    .sin_t_i (sin_t),
    .cos_t_i (cos_t),
    .sin_a_i (sin_a),
    .cos_a_i (cos_a),
    .len_i   (a_q[NumIter+1]),
    .r00_o   (r00_o),
    .r01_o   (r01_o),
    .r02_o   (r02_o),
    .p0_o    (p0_o),
    .r10_o   (r10_o),
    .r11_o   (r11_o),
    .r12_o   (r12_o),
    .p1_o    (p1_o),
    .r21_o   (r21_o),
    .r22_o   (r22_o)
  );

  assign p2_o = d_q[NumStg-1];

  // Back-pressure reaches the input only when the whole pipe is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled while pipeline has room");

  // An accepted item lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> valid_q[0])
    else $error("accepted item lost at entry stage");

  // Output drains when taken and nothing follows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && !valid_q[NumStg-2]) |=> !valid_o)
    else $error("result repeated after being taken");

  // Rotation entries r01 and r12 stay within the Q1.14 clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (r01_o >= TrigMin && r01_o <= TrigMax &&
                 r12_o >= TrigMin && r12_o <= TrigMax))
    else $error("rotation entry outside clamp range");

endmodule

### src/dhtm_cordic.sv
// Pipelined rotation-mode CORDIC: one angle in, Q1.14 sine and cosine out.
module dhtm_cordic import dhtm_pkg::*; #(
  parameter int NumIter = 16
) (
  input  logic               clk_i,
  input  logic [NumIter+1:0] en_i,
  input  word_t              angle_i,
  output word_t              sin_o,
  output word_t              cos_o
);

  logic signed [ZW-1:0] z_wide;
  logic signed [ZW-1:0] z_red;
  logic                 flip_red;

  logic signed [XW-1:0] x_q    [NumIter+1];
  logic signed [XW-1:0] y_q    [NumIter+1];
  logic signed [ZW-1:0] z_q    [NumIter+1];
  logic                 flip_q [NumIter+1];

  logic signed [XW-1:0] xf, yf;
  logic signed [XW-1:0] xr, yr;
  word_t                sin_d, cos_d;
  word_t                sin_q, cos_q;

  // Widen to Q30 and fold into [-pi/2, pi/2]
  always_comb begin
    z_wide   = {angle_i[15], angle_i, 17'd0};
    z_red    = z_wide;
    flip_red = 1'b0;
    if (z_wide > HalfPiQ30) begin
      z_red    = z_wide - PiQ30;
      flip_red = 1'b1;
    end else if (z_wide < -HalfPiQ30) begin
      z_red    = z_wide + PiQ30;
      flip_red = 1'b1;
    end
  end

  // Entry stage
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q[0]    <= GainQ30;
      y_q[0]    <= '0;
      z_q[0]    <= z_red;
      flip_q[0] <= flip_red;
    end
  end

  // One micro-rotation per stage
  for (genvar k = 0; k < NumIter; k++) begin : g_step
    logic signed [XW-1:0] xs, ys;
    logic signed [XW-1:0] x_d, y_d;
    logic signed [ZW-1:0] z_d;
    logic signed [ZW-1:0] at;

    assign at = $signed({2'b00, AtanQ30[k]});

    always_comb begin
      xs = x_q[k] >>> k;
      ys = y_q[k] >>> k;
      if (!z_q[k][ZW-1]) begin
        x_d = x_q[k] - ys;
        y_d = y_q[k] + xs;
        z_d = z_q[k] - at;
      end else begin
        x_d = x_q[k] + ys;
        y_d = y_q[k] - xs;
        z_d = z_q[k] + at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k+1]) begin
        x_q[k+1]    <= x_d;
        y_q[k+1]    <= y_d;
        z_q[k+1]    <= z_d;
        flip_q[k+1] <= flip_q[k];
      end
    end
  end

  // Undo the fold, round to Q1.14 and clamp
  always_comb begin
    xf = flip_q[NumIter] ? -x_q[NumIter] : x_q[NumIter];
    yf = flip_q[NumIter] ? -y_q[NumIter] : y_q[NumIter];
    xr = (xf + 32'sd32768) >>> 16;
    yr = (yf + 32'sd32768) >>> 16;
    if (xr > 32'sd16384) begin
      cos_d = TrigMax;
    end else if (xr < -32'sd16384) begin
      cos_d = TrigMin;
    end else begin
      cos_d = xr[15:0];
    end
    if (yr > 32'sd16384) begin
      sin_d = TrigMax;
    end else if (yr < -32'sd16384) begin
      sin_d = TrigMin;
    end else begin
      sin_d = yr[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NumIter+1]) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

### src/dhtm_mult.sv
// Product stage and output register: trig and length products, rounded and saturated.
module dhtm_mult import dhtm_pkg::*; (
  input  logic       clk_i,
  input  logic [1:0] en_i,
  input  word_t      sin_t_i,
  input  word_t      cos_t_i,
  input  word_t      sin_a_i,
  input  word_t      cos_a_i,
  input  word_t      len_i,
  output word_t      r00_o,
  output word_t      r01_o,
  output word_t      r02_o,
  output word_t      p0_o,
  output word_t      r10_o,
  output word_t      r11_o,
  output word_t      r12_o,
  output word_t      p1_o,
  output word_t      r21_o,
  output word_t      r22_o
);

  // Round half up by 2^14, clamp to the Q1.14 trig range
  function automatic word_t sat_trig(input logic signed [31:0] p);
    logic signed [31:0] r;
    r = (p + 32'sd8192) >>> 14;
    if (r > 32'sd16384) begin
      return TrigMax;
    end else if (r < -32'sd16384) begin
      return TrigMin;
    end
    return r[15:0];
  endfunction

  // Round half up by 2^14, saturate to Q4.12
  function automatic word_t sat_len(input logic signed [31:0] p);
    logic signed [31:0] r;
    r = (p + 32'sd8192) >>> 14;
    if (r > 32'sd32767) begin
      return LenMax;
    end else if (r < -32'sd32768) begin
      return LenMin;
    end
    return r[15:0];
  endfunction

  logic signed [31:0] st_ca_q, st_sa_q, ct_ca_q, ct_sa_q, a_ct_q, a_st_q;
  word_t              st_q, ct_q, sa_q, ca_q;

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      st_ca_q <= sin_t_i * cos_a_i;
      st_sa_q <= sin_t_i * sin_a_i;
      ct_ca_q <= cos_t_i * cos_a_i;
      ct_sa_q <= cos_t_i * sin_a_i;
      a_ct_q  <= len_i * cos_t_i;
      a_st_q  <= len_i * sin_t_i;
      st_q    <= sin_t_i;
      ct_q    <= cos_t_i;
      sa_q    <= sin_a_i;
      ca_q    <= cos_a_i;
    end
  end

  word_t r01_d, r02_d, p0_d, r11_d, r12_d, p1_d;

  // Rounding, saturation, sign
  always_comb begin
    r01_d = -sat_trig(st_ca_q);
    r02_d = sat_trig(st_sa_q);
    p0_d  = sat_len(a_ct_q);
    r11_d = sat_trig(ct_ca_q);
    r12_d = -sat_trig(ct_sa_q);
    p1_d  = sat_len(a_st_q);
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      r00_o <= ct_q;
      r01_o <= r01_d;
      r02_o <= r02_d;
      p0_o  <= p0_d;
      r10_o <= st_q;
      r11_o <= r11_d;
      r12_o <= r12_d;
      p1_o  <= p1_d;
      r21_o <= sa_q;
      r22_o <= ca_q;
    end
  end

endmodule

### tb/sv/dh_transform_checker.sv
// Checker for the DH transform: predicts each transform and compares the results.
`timescale 1ns / 100ps

module dh_transform_checker #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  dhtm_pkg::word_t  length_i,
  input  dhtm_pkg::word_t  twist_i,
  input  dhtm_pkg::word_t  offset_i,
  input  dhtm_pkg::word_t  angle_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [10:0][15:0] entries_i,  // r00 in slot 0 up to p2 in slot 10
  output int               mismatches_o,
  output int               pending_o
);

  typedef logic [10:0][15:0] entries_t;

  localparam int StepsUsed = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;

  // Q30 constants of the rotation
  localparam longint CordicGain = 64'sd652032874;
  localparam longint HalfPi     = 64'sd1686629713;
  localparam longint FullPi     = 64'sd3373259426;
  localparam longint TrigFull   = 16384;
  localparam longint LenHi      = 32767;
  localparam longint LenLo      = -32768;

  // atan(2^-i), Q30, truncated
  localparam longint AtanSteps [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  string entry_name [11] = '{"r00", "r01", "r02", "p0", "r10", "r11", "r12", "p1",
                             "r21", "r22", "p2"};

  entries_t transforms_due [$];
  entries_t want;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Sine and cosine of a Q3.13 angle, Q1.14 each; angles past pi/2 fold by pi
  function automatic void sin_cos(input dhtm_pkg::word_t ang, output longint s,
                                  output longint c);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 131072;
    x = CordicGain;
    y = 0;
    flip = 1'b0;
    if (z > HalfPi) begin
      z -= FullPi;
      flip = 1'b1;
    end else if (z < -HalfPi) begin
      z += FullPi;
      flip = 1'b1;
    end
    for (int i = 0; i < StepsUsed; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= AtanSteps[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += AtanSteps[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip((x + 32768) >>> 16, -TrigFull, TrigFull);
    s = clip((y + 32768) >>> 16, -TrigFull, TrigFull);
  endfunction

  // Q1.14 x Q1.14, round half up
  function automatic longint trig_product(longint p, longint q);
    return clip((p * q + 8192) >>> 14, -TrigFull, TrigFull);
  endfunction

  // Q4.12 x Q1.14, round half up, saturate
  function automatic longint length_product(longint a, longint t);
    return clip((a * t + 8192) >>> 14, LenLo, LenHi);
  endfunction

  function automatic entries_t transform(dhtm_pkg::word_t a, dhtm_pkg::word_t al,
                                         dhtm_pkg::word_t d, dhtm_pkg::word_t th);
    longint st, ct, sa, ca;
    entries_t m;
    sin_cos(th, st, ct);
    sin_cos(al, sa, ca);
    m[0]  = 16'(ct);
    m[1]  = 16'(-trig_product(st, ca));
    m[2]  = 16'(trig_product(st, sa));
    m[3]  = 16'(length_product(a, ct));
    m[4]  = 16'(st);
    m[5]  = 16'(trig_product(ct, ca));
    m[6]  = 16'(-trig_product(ct, sa));
    m[7]  = 16'(length_product(a, st));
    m[8]  = 16'(sa);
    m[9]  = 16'(ca);
    m[10] = d;
    return m;
  endfunction

  // Queue a transform per accepted item, compare each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        transforms_due.push_back(transform(length_i, twist_i, offset_i, angle_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (transforms_due.size() == 0) begin
          $display("%0t: result with no item outstanding", $time);
          mismatches_o++;
        end else begin
          want = transforms_due.pop_front();
          for (int k = 0; k < 11; k++) begin
            if (want[k] !== entries_i[k]) begin
              $display("%0t: %s expected %0d, got %0d", $time, entry_name[k],
                       $signed(want[k]), $signed(entries_i[k]));
              mismatches_o++;
            end
          end
        end
      end
      pending_o = transforms_due.size();
    end
  end

endmodule

### tb/sv/tb_dh_transform_matrix.sv
// Testbench top for the DH transform: drives items with random gaps and stalls, gives verdict.
`timescale 1ns / 100ps

module tb_dh_transform_matrix;
  import dhtm_pkg::word_t;

  localparam int CordicSteps = 16;
  localparam int RandomItems = 1800;
  localparam int CycleLimit  = 500000;
  localparam int AngleLimit  = 25736;   // pi in Q3.13
  localparam int HalfPiAngle = 12868;   // pi/2 in Q3.13, rounded

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  valid_i = 1'b0;
  logic  stall_i = 1'b0;
  word_t link_length_i = '0;
  word_t link_twist_i = '0;
  word_t link_offset_i = '0;
  word_t joint_angle_i = '0;
  logic  stall_o, valid_o;
  word_t r00_o, r01_o, r02_o, p0_o, r10_o, r11_o, r12_o, p1_o, r21_o, r22_o, p2_o;

  int mismatches, pending;
  int cycle_count = 0;
  int send_calm = 0;
  int take_calm = 0;

  dh_transform_matrix #(.CORDIC_ITERATIONS(CordicSteps)) dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .link_length_i, .link_twist_i, .link_offset_i, .joint_angle_i,
    .valid_o, .stall_i,
    .r00_o, .r01_o, .r02_o, .p0_o, .r10_o, .r11_o, .r12_o, .p1_o, .r21_o, .r22_o, .p2_o
  );

  dh_transform_checker #(.CORDIC_ITERATIONS(CordicSteps)) checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(valid_i), .in_stall_i(stall_o),
    .length_i(link_length_i), .twist_i(link_twist_i),
    .offset_i(link_offset_i), .angle_i(joint_angle_i),
    .out_valid_i(valid_o), .out_stall_i(stall_i),
    .entries_i({p2_o, r22_o, r21_o, p1_o, r12_o, r11_o, r10_o, p0_o, r02_o, r01_o, r00_o}),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Random wait before each item, with occasional back-to-back stretches
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(15, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic word_t any_angle();
    return word_t'(int'($urandom_range(0, 2 * AngleLimit)) - AngleLimit);
  endfunction

  // Angles close to zero and to the fold points at +-pi/2 and +-pi
  function automatic word_t fold_angle();
    int v;
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = HalfPiAngle;
      2: v = -HalfPiAngle;
      3: v = AngleLimit;
      default: v = -AngleLimit;
    endcase
    v = v + int'($urandom_range(0, 16)) - 8;
    if (v > AngleLimit) v = AngleLimit;
    if (v < -AngleLimit) v = -AngleLimit;
    return word_t'(v);
  endfunction

  function automatic word_t edge_length();
    case ($urandom_range(0, 5))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return 16'sd0;
      3: return 16'sd1;
      4: return -16'sd1;
      default: return word_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Present one item and hold it until accepted
  task automatic send_joint(input word_t a, input word_t al, input word_t d, input word_t th);
    int gap;
    bit taken;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    link_length_i <= a;
    link_twist_i  <= al;
    link_offset_i <= d;
    joint_angle_i <= th;
    do begin
      @(negedge clk_i);
      taken = !stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Result side: random stall before each result
  initial begin : result_sink
    int hold;
    bit taken;
    @(posedge rst_ni);
    forever begin
      hold = draw_wait(take_calm);
      if (hold > 0) begin
        stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        taken = valid_o;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  // Cycle limit
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    word_t a, al, d, th;
    int pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, length extremes, angles at and beside the fold points and at +-pi
    send_joint(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_joint(16'sd32767, 16'sd0, 16'sd32767, 16'sd0);
    send_joint(-16'sd32768, 16'sd0, -16'sd32768, 16'sd0);
    send_joint(-16'sd32768, 16'sd25736, 16'sd32767, 16'sd25736);   // a*cos saturates high
    send_joint(-16'sd32768, -16'sd25736, -16'sd1, -16'sd25736);
    send_joint(16'sd32767, 16'sd25736, 16'sd0, -16'sd25736);
    send_joint(16'sd32767, 16'sd12867, 16'sd1, 16'sd12868);
    send_joint(16'sd4096, 16'sd12868, -16'sd1, 16'sd12867);
    send_joint(16'sd4096, -16'sd12867, 16'sd0, -16'sd12868);
    send_joint(-16'sd4096, -16'sd12868, 16'sd100, -16'sd12867);
    send_joint(-16'sd32768, 16'sd12868, 16'sd0, 16'sd12868);
    send_joint(16'sd32767, -16'sd12868, 16'sd0, -16'sd12868);
    send_joint(16'sd12345, 16'sd8579, -16'sd12345, 16'sd6434);
    send_joint(16'sd32767, 16'sd6434, -16'sd32768, -16'sd6434);
    send_joint(16'sd1, 16'sd1, 16'sd1, -16'sd1);
    send_joint(-16'sd1, -16'sd1, -16'sd1, 16'sd1);
    send_joint(16'sd21845, 16'sd5461, -16'sd21846, -16'sd5462);     // alternating bits
    send_joint(-16'sd21846, -16'sd5462, 16'sd21845, 16'sd5461);
    send_joint(16'sd32767, 16'sd24575, 16'sd0, -16'sd24576);

    // Random items
    for (int n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(0, 9);
      a  = word_t'($urandom_range(0, 65535));
      d  = word_t'($urandom_range(0, 65535));
      al = any_angle();
      th = any_angle();
      if (pick >= 6 && pick <= 7) begin
        al = fold_angle();
        th = fold_angle();
      end else if (pick >= 8) begin
        a = edge_length();
        d = edge_length();
      end
      send_joint(a, al, d, th);
    end
    valid_i <= 1'b0;

    // Drain, then let the pipeline settle
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
